[rtl/fbfla_pkg.sv]
// Package for the fixed-size block pool allocator.
// Holds mode and status codes, register indexes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package fbfla_pkg;

  // Field widths fixed by the interface
  localparam int MODE_W   = 3;
  localparam int FIDX_W   = 12;
  localparam int STATUS_W = 3;
  localparam int OFFS_W   = 28;
  localparam int USED_W   = 13;
  localparam int BCNT_W   = 13;
  localparam int BBYT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OPEN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLOSE   = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] STS_REFUSED      = 3'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY        = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_ALL_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] STS_UNDERFLOW    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;

  // Reset values of the configuration registers
  localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;
  localparam logic [BBYT_W-1:0] BLOCK_BYTES_RST = 16'd64;

  // Used counter saturation point
  localparam logic [USED_W-1:0] USED_MAX = 13'h1FFF;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_LINK
  } state_t;

endpackage

[rtl/fixed_block_free_list_allocator_unit.sv]
// Fixed-size block pool allocator: LIFO free list over a next-link memory.
// Depends on fbfla_pkg.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive in_mode / in_free_index with start; a beat is taken
//   on a clock edge where start is high and busy is low. One result per beat
//   appears on the out_ ports for exactly one cycle, marked by out_valid.
//   Results cannot be stalled by the receiver; none is held back or dropped.
//   Config channel: cfg_valid / cfg_ready write cfg_data into register
//   cfg_index (0 block_count, 1 block_bytes); cfg_ready is always high.
//   Write configuration only while the block is idle.
// Timing
//   free, release, close, open-while-open, refused or empty commands: result
//   in the cycle after acceptance, next beat accepted in that same cycle.
//   allocate that grants a block: busy in the alloc state while the head entry
//   is read from the link memory, whose read is registered; then the result.
//   open from closed: busy while the link state writes one link-memory entry
//   per cycle for each block of the effective block count, then the result.
// Reset
//   Synchronous, active low: pool closed, releasing set, used count zero,
//   list empty, config registers at 4096 blocks of 64 bytes. The link
//   memory is not cleared; open writes every entry it later reads.
module fixed_block_free_list_allocator_unit #(
  parameter int NUM_BLOCKS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [fbfla_pkg::MODE_W-1:0]       in_mode,
  input  logic [fbfla_pkg::FIDX_W-1:0]       in_free_index,
  // result channel
  output logic                               out_valid,
  output logic [fbfla_pkg::STATUS_W-1:0]     out_status,
  output logic [fbfla_pkg::FIDX_W-1:0]       out_block_index,
  output logic [fbfla_pkg::OFFS_W-1:0]       out_byte_offset,
  output logic [fbfla_pkg::USED_W-1:0]       out_used_count,
  output logic                               out_all_free,
  output logic                               out_pool_open,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fbfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int LW    = IDX_W + 1;  // link entry: valid bit over index

  // Link memory
  logic [LW-1:0] link_mem [NUM_BLOCKS];
  logic [LW-1:0] rd_data_r;
  logic          mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [LW-1:0]    mem_wdata;

  // Control and pool state
  fbfla_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic             head_vld_r, head_vld_nxt;
  logic [fbfla_pkg::USED_W-1:0] used_r, used_nxt;
  logic             open_r, open_nxt;
  logic             rel_r, rel_nxt;
  logic [IDX_W-1:0] link_idx_r, link_idx_nxt;
  logic [IDX_W-1:0] link_last_r, link_last_nxt;

  // Configuration registers
  logic [fbfla_pkg::BCNT_W-1:0] blk_cnt_r;
  logic [fbfla_pkg::BBYT_W-1:0] blk_bytes_r;

  // Result registers
  logic                           out_vld_r, out_vld_nxt;
  logic [fbfla_pkg::STATUS_W-1:0] out_sts_r, out_sts_nxt;
  logic [fbfla_pkg::FIDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [fbfla_pkg::OFFS_W-1:0]   out_offs_r, out_offs_nxt;
  logic [fbfla_pkg::USED_W-1:0]   out_used_r, out_used_nxt;
  logic                           out_af_r, out_af_nxt;
  logic                           out_open_r, out_open_nxt;

  logic        accept;
  logic        alloc_go;
  logic        fidx_oob;
  logic        link_last;
  logic [31:0] cnt_ext;
  logic [IDX_W-1:0] eff_last;
  logic [31:0] prod;

  assign accept    = start && (state_r == fbfla_pkg::S_IDLE);
  assign busy      = (state_r != fbfla_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign alloc_go  = !rel_r && open_r && head_vld_r;
  assign fidx_oob  = 32'(in_free_index) >= 32'(NUM_BLOCKS);
  assign link_last = (link_idx_r == link_last_r);
  assign prod      = 32'(head_r) * 32'(blk_bytes_r);

  // Last block index linked at open: count clamped to 1..NUM_BLOCKS
  assign cnt_ext = 32'(blk_cnt_r);
  always_comb begin
    if (blk_cnt_r == '0) begin
      eff_last = '0;
    end else if (cnt_ext > 32'(NUM_BLOCKS)) begin
      eff_last = IDX_W'(NUM_BLOCKS - 1);
    end else begin
      eff_last = IDX_W'(cnt_ext - 32'd1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fbfla_pkg::S_IDLE: begin
        if (accept) begin
          if (in_mode == fbfla_pkg::MODE_ALLOC && alloc_go) begin
            state_nxt = fbfla_pkg::S_ALLOC;
          end else if (in_mode == fbfla_pkg::MODE_OPEN && !open_r) begin
            state_nxt = fbfla_pkg::S_LINK;
          end
        end
      end
      fbfla_pkg::S_ALLOC: state_nxt = fbfla_pkg::S_IDLE;
      fbfla_pkg::S_LINK: begin
        if (link_last) state_nxt = fbfla_pkg::S_IDLE;
      end
      default: state_nxt = fbfla_pkg::S_IDLE;
    endcase
  end

  // Pool updates, memory writes and result
  always_comb begin
    head_nxt      = head_r;
    head_vld_nxt  = head_vld_r;
    used_nxt      = used_r;
    open_nxt      = open_r;
    rel_nxt       = rel_r;
    link_idx_nxt  = link_idx_r;
    link_last_nxt = link_last_r;
    mem_we        = 1'b0;
    mem_waddr     = link_idx_r;
    mem_wdata     = '0;
    out_vld_nxt   = 1'b0;
    out_sts_nxt   = out_sts_r;
    out_idx_nxt   = out_idx_r;
    out_offs_nxt  = out_offs_r;
    out_used_nxt  = out_used_r;
    out_af_nxt    = out_af_r;
    out_open_nxt  = out_open_r;

    case (state_r)
      fbfla_pkg::S_IDLE: begin
        if (accept) begin
          out_idx_nxt  = '0;
          out_offs_nxt = '0;
          out_sts_nxt  = fbfla_pkg::STS_OK;
          out_vld_nxt  = 1'b1;
          case (in_mode)
            fbfla_pkg::MODE_ALLOC: begin
              if (rel_r || !open_r) begin
                out_sts_nxt = fbfla_pkg::STS_REFUSED;
              end else if (!head_vld_r) begin
                out_sts_nxt = fbfla_pkg::STS_EMPTY;
              end else begin
                // head entry read is in flight; result is set in the alloc state
                out_vld_nxt = 1'b0;
              end
            end
            fbfla_pkg::MODE_FREE: begin
              if (!open_r || fidx_oob) begin
                out_sts_nxt = fbfla_pkg::STS_REFUSED;
              end else begin
                // push: freed block links to the old head
                mem_we       = 1'b1;
                mem_waddr    = IDX_W'(in_free_index);
                mem_wdata    = {head_vld_r, head_r};
                head_nxt     = IDX_W'(in_free_index);
                head_vld_nxt = 1'b1;
                if (used_r == '0) begin
                  out_sts_nxt = fbfla_pkg::STS_UNDERFLOW;
                end else begin
                  used_nxt = used_r - 1'b1;
                end
              end
            end
            fbfla_pkg::MODE_OPEN: begin
              if (!open_r) begin
                out_vld_nxt   = 1'b0;
                link_idx_nxt  = '0;
                link_last_nxt = eff_last;
              end
            end
            fbfla_pkg::MODE_RELEASE: begin
              rel_nxt = 1'b1;
            end
            fbfla_pkg::MODE_CLOSE: begin
              rel_nxt = 1'b1;
              if (used_r != '0) begin
                out_sts_nxt = fbfla_pkg::STS_NOT_ALL_FREE;
              end else begin
                open_nxt     = 1'b0;
                head_vld_nxt = 1'b0;
                head_nxt     = '0;
              end
            end
            default: begin
              out_sts_nxt = fbfla_pkg::STS_REFUSED;
            end
          endcase
        end
      end

      fbfla_pkg::S_ALLOC: begin
        // pop: head moves to the link read last cycle
        head_nxt     = rd_data_r[IDX_W-1:0];
        head_vld_nxt = rd_data_r[IDX_W];
        if (used_r != fbfla_pkg::USED_MAX) used_nxt = used_r + 1'b1;
        out_vld_nxt  = 1'b1;
        out_sts_nxt  = fbfla_pkg::STS_OK;
        out_idx_nxt  = fbfla_pkg::FIDX_W'(head_r);
        out_offs_nxt = prod[fbfla_pkg::OFFS_W-1:0];
      end

      fbfla_pkg::S_LINK: begin
        // one entry per cycle, ascending; last block ends the list
        mem_we       = 1'b1;
        mem_waddr    = link_idx_r;
        mem_wdata    = link_last ? '0 : {1'b1, IDX_W'(link_idx_r + 1'b1)};
        link_idx_nxt = IDX_W'(link_idx_r + 1'b1);
        if (link_last) begin
          head_nxt     = '0;
          head_vld_nxt = 1'b1;
          open_nxt     = 1'b1;
          rel_nxt      = 1'b0;
          out_vld_nxt  = 1'b1;
          out_sts_nxt  = fbfla_pkg::STS_OK;
          out_idx_nxt  = '0;
          out_offs_nxt = '0;
        end
      end

      default: ;
    endcase

    // counters and flags as they stand after the command
    if (out_vld_nxt) begin
      out_used_nxt = used_nxt;
      out_af_nxt   = (used_nxt == '0);
      out_open_nxt = open_nxt;
    end
  end

  // Link memory: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= link_mem[head_r];
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbfla_pkg::S_IDLE;
      head_r      <= '0;
      head_vld_r  <= 1'b0;
      used_r      <= '0;
      open_r      <= 1'b0;
      rel_r       <= 1'b1;
      out_vld_r   <= 1'b0;
      blk_cnt_r   <= fbfla_pkg::BLOCK_COUNT_RST;
      blk_bytes_r <= fbfla_pkg::BLOCK_BYTES_RST;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      head_vld_r <= head_vld_nxt;
      used_r     <= used_nxt;
      open_r     <= open_nxt;
      rel_r      <= rel_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fbfla_pkg::REG_BLOCK_COUNT: blk_cnt_r   <= cfg_data[fbfla_pkg::BCNT_W-1:0];
          fbfla_pkg::REG_BLOCK_BYTES: blk_bytes_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    link_idx_r  <= link_idx_nxt;
    link_last_r <= link_last_nxt;
    out_sts_r   <= out_sts_nxt;
    out_idx_r   <= out_idx_nxt;
    out_offs_r  <= out_offs_nxt;
    out_used_r  <= out_used_nxt;
    out_af_r    <= out_af_nxt;
    out_open_r  <= out_open_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_sts_r;
  assign out_block_index = out_idx_r;
  assign out_byte_offset = out_offs_r;
  assign out_used_count  = out_used_r;
  assign out_all_free    = out_af_r;
  assign out_pool_open   = out_open_r;

endmodule

[rtl/fbfla_checker.sv]
// Port-level checks for the block pool allocator, bound to the top level.
// Depends on fbfla_pkg and fixed_block_free_list_allocator_unit.
`timescale 1ns / 1ps

module fbfla_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [fbfla_pkg::STATUS_W-1:0]     out_status,
  input logic [fbfla_pkg::FIDX_W-1:0]       out_block_index,
  input logic [fbfla_pkg::OFFS_W-1:0]       out_byte_offset,
  input logic [fbfla_pkg::USED_W-1:0]       out_used_count,
  input logic                               out_all_free
);

  // reset leaves no result pending and the block idle
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("result or busy after reset");

  // an accepted beat either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted beat neither answered nor in progress");

  // no result is shown while a command is still in progress
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while busy");

  // all_free tracks the reported count
  a_all_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_all_free == (out_used_count == '0))
    else $error("all_free disagrees with used count");

  // only a successful grant carries an index or offset
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fbfla_pkg::STS_OK
      |-> out_block_index == '0 && out_byte_offset == '0)
    else $error("block index or offset on a failed command");

endmodule

bind fixed_block_free_list_allocator_unit fbfla_checker u_fbfla_checker (.*);
